>>> rtl/rbm_pkg.sv
package rbm_pkg;

    localparam int WORD_BITS  = 64;
    localparam int RAD_W      = 11;
    localparam int START_W    = 10;
    localparam int ROWW_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int BIT_W      = 6;
    localparam int WHOLE_W    = RAD_W - BIT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WORDS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_RADIUS   = 2'd3;

    localparam logic [ROWW_W-1:0] ROW_WORDS_RST  = 5'd16;
    localparam logic [RAD_W-1:0]  END_RADIUS_RST = 11'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_P0,
        S_P1,
        S_P2,
        S_PW,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    // which pair of snapshot words the two read ports fetch
    typedef enum logic [1:0] {
        RD_MID_UPH,
        RD_UPL_DNL,
        RD_DNH
    } t_rd_sel;

    typedef struct packed {
        logic    in_ready;
        t_rd_sel rd_sel;
        logic    cap0;
        logic    cap1;
        logic    wr_pass;
        logic    pass_begin;
        logic    pass_end;
        logic    idx_clr;
        logic    idx_inc;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        logic row_done;
        logic a_lt_end;
        logic idx_last;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/rbm_ifs.sv
interface rbm_in_if;
    logic                           valid;
    logic                           ready;
    logic [rbm_pkg::WORD_BITS-1:0]  row_word;

    modport source (output valid, output row_word, input ready);
    modport sink   (input valid, input row_word, output ready);
endinterface

interface rbm_out_if;
    logic                           valid;
    logic                           ready;
    logic [rbm_pkg::WORD_BITS-1:0]  result_word;
    logic                           row_end;

    modport source (output valid, output result_word, output row_end, input ready);
    modport sink   (input valid, input result_word, input row_end, output ready);
endinterface

>>> rtl/rbm_ctrl.sv
module rbm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbm_pkg::t_stat i_stat,
    output rbm_pkg::t_cmd  o_cmd
);

    rbm_pkg::t_state r_state;
    rbm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rbm_pkg::S_IDLE: begin
                if (i_stat.in_fire && i_stat.row_done) begin
                    n_state = rbm_pkg::S_CHECK;
                end
            end
            rbm_pkg::S_CHECK: begin
                n_state = i_stat.a_lt_end ? rbm_pkg::S_P0 : rbm_pkg::S_EMIT_RD;
            end
            rbm_pkg::S_P0: n_state = rbm_pkg::S_P1;
            rbm_pkg::S_P1: n_state = rbm_pkg::S_P2;
            rbm_pkg::S_P2: n_state = rbm_pkg::S_PW;
            rbm_pkg::S_PW: begin
                n_state = i_stat.idx_last ? rbm_pkg::S_CHECK : rbm_pkg::S_P0;
            end
            rbm_pkg::S_EMIT_RD: n_state = rbm_pkg::S_EMIT_LD;
            rbm_pkg::S_EMIT_LD: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.idx_last ? rbm_pkg::S_IDLE : rbm_pkg::S_EMIT_RD;
                end
            end
            default: n_state = rbm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = rbm_pkg::RD_MID_UPH;
        case (r_state)
            rbm_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            rbm_pkg::S_CHECK: begin
                if (i_stat.a_lt_end) begin
                    o_cmd.pass_begin = 1'b1;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                end
            end
            rbm_pkg::S_P0: begin
                o_cmd.rd_sel = rbm_pkg::RD_MID_UPH;
            end
            rbm_pkg::S_P1: begin
                o_cmd.rd_sel = rbm_pkg::RD_UPL_DNL;
                o_cmd.cap0   = 1'b1;
            end
            rbm_pkg::S_P2: begin
                o_cmd.rd_sel = rbm_pkg::RD_DNH;
                o_cmd.cap1   = 1'b1;
            end
            rbm_pkg::S_PW: begin
                o_cmd.wr_pass = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.pass_end = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            rbm_pkg::S_EMIT_RD: begin
                o_cmd.rd_sel = rbm_pkg::RD_MID_UPH;
            end
            rbm_pkg::S_EMIT_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.idx_inc  = !i_stat.idx_last;
                end
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/rbm_dp.sv
module rbm_dp #(
    parameter int MAX_ROW_WORDS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rbm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rbm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  rbm_pkg::t_cmd                    i_cmd,
    output rbm_pkg::t_stat                   o_stat,
    rbm_in_if.sink                           i_in,
    rbm_out_if.source                        o_out
);

    localparam int IW    = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    localparam int LW    = $clog2(MAX_ROW_WORDS + 1);
    localparam int EW    = ((IW > rbm_pkg::WHOLE_W) ? IW : rbm_pkg::WHOLE_W) + 2;
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int WB    = rbm_pkg::WORD_BITS;
    localparam int RW    = rbm_pkg::RAD_W;
    localparam int SW    = rbm_pkg::BIT_W + 1;

    // configuration
    logic                        r_op;
    logic [rbm_pkg::ROWW_W-1:0]  r_row_words;
    logic [rbm_pkg::START_W-1:0] r_start;
    logic [RW-1:0]               r_end;

    // control
    logic [IW-1:0]  r_wcnt;
    logic [IW-1:0]  r_idx;
    logic           r_bank;
    logic [RW-1:0]  r_a;
    logic [RW-1:0]  r_c;
    logic           r_out_valid;

    // data
    logic [WB-1:0]  r_mem [DEPTH];
    logic [WB-1:0]  r_rd0;
    logic [WB-1:0]  r_rd1;
    logic [WB-1:0]  r_mid;
    logic [WB-1:0]  r_uph;
    logic [WB-1:0]  r_upl;
    logic [WB-1:0]  r_dnl;
    logic [WB-1:0]  r_out_word;
    logic           r_out_end;

    logic [LW-1:0]  len;
    logic           in_fire;
    logic [EW-1:0]  i_e;
    logic [EW-1:0]  whole_e;
    logic [EW-1:0]  len_e;
    logic [EW-1:0]  j_up_e;
    logic [EW-1:0]  j_dn_e;
    logic           up_ok;
    logic           upl_ok;
    logic           dn_ok;
    logic           dnh_ok;
    logic [IW-1:0]  rd_idx0;
    logic [IW-1:0]  rd_idx1;
    logic [AW-1:0]  wr_addr;
    logic [WB-1:0]  wr_data;
    logic           wr_en;
    logic [RW:0]    two_a1;
    logic [RW-1:0]  a_rem;
    logic [RW-1:0]  c_next;
    logic [SW-1:0]  sh_lo;
    logic [SW-1:0]  sh_hi;
    logic [WB-1:0]  up_w;
    logic [WB-1:0]  dn_w;
    logic [WB-1:0]  pass_w;

    always_comb begin
        if (r_row_words == '0) begin
            len = LW'(1);
        end else if (int'(r_row_words) > MAX_ROW_WORDS) begin
            len = LW'(MAX_ROW_WORDS);
        end else begin
            len = LW'(r_row_words);
        end
    end

    assign in_fire     = i_in.valid && i_cmd.in_ready;
    assign i_in.ready  = i_cmd.in_ready;

    assign i_e     = EW'(r_idx);
    assign whole_e = EW'(r_c[RW-1:rbm_pkg::BIT_W]);
    assign len_e   = EW'(len);
    assign j_up_e  = i_e - whole_e;
    assign j_dn_e  = i_e + whole_e;
    assign up_ok   = i_e >= whole_e;
    assign upl_ok  = i_e >= whole_e + EW'(1);
    assign dn_ok   = j_dn_e < len_e;
    assign dnh_ok  = j_dn_e + EW'(1) < len_e;

    // doubling step: reach c = min(2a+1, end-a)
    assign two_a1 = {r_a, 1'b1};
    assign a_rem  = r_end - r_a;
    assign c_next = (two_a1 < {1'b0, a_rem}) ? two_a1[RW-1:0] : a_rem;

    assign o_stat.in_fire  = in_fire;
    assign o_stat.row_done = (EW'(r_wcnt) + EW'(1)) >= len_e;
    assign o_stat.a_lt_end = r_a < r_end;
    assign o_stat.idx_last = (i_e + EW'(1)) == len_e;
    assign o_stat.out_free = !r_out_valid || o_out.ready;

    always_comb begin
        rd_idx0 = r_idx;
        rd_idx1 = j_up_e[IW-1:0];
        case (i_cmd.rd_sel)
            rbm_pkg::RD_MID_UPH: begin
                rd_idx0 = r_idx;
                rd_idx1 = j_up_e[IW-1:0];
            end
            rbm_pkg::RD_UPL_DNL: begin
                rd_idx0 = IW'(j_up_e - EW'(1));
                rd_idx1 = j_dn_e[IW-1:0];
            end
            rbm_pkg::RD_DNH: begin
                rd_idx0 = IW'(j_dn_e + EW'(1));
                rd_idx1 = j_dn_e[IW-1:0];
            end
            default: begin
                rd_idx0 = r_idx;
                rd_idx1 = r_idx;
            end
        endcase
    end

    // shifted copies; a shift by the full word width gives zero
    assign sh_lo = SW'(r_c[rbm_pkg::BIT_W-1:0]);
    assign sh_hi = SW'(WB) - sh_lo;

    always_comb begin
        up_w = '0;
        dn_w = '0;
        if (up_ok) begin
            up_w = r_uph << sh_lo;
            if (upl_ok) begin
                up_w = up_w | (r_upl >> sh_hi);
            end
        end
        if (dn_ok) begin
            dn_w = r_dnl >> sh_lo;
            if (dnh_ok) begin
                dn_w = dn_w | (r_rd0 << sh_hi);
            end
        end
        pass_w = r_op ? (r_mid & up_w & dn_w) : (r_mid | up_w | dn_w);
    end

    always_comb begin
        wr_en   = in_fire || i_cmd.wr_pass;
        wr_addr = {r_bank, r_wcnt};
        wr_data = i_in.row_word;
        if (i_cmd.wr_pass) begin
            wr_addr = {!r_bank, r_idx};
            wr_data = pass_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd0 <= r_mem[{r_bank, rd_idx0}];
        r_rd1 <= r_mem[{r_bank, rd_idx1}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap0) begin
            r_mid <= r_rd0;
            r_uph <= r_rd1;
        end
        if (i_cmd.cap1) begin
            r_upl <= r_rd0;
            r_dnl <= r_rd1;
        end
        if (i_cmd.out_load) begin
            r_out_word <= r_rd0;
            r_out_end  <= o_stat.idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= 1'b0;
            r_row_words <= rbm_pkg::ROW_WORDS_RST;
            r_start     <= '0;
            r_end       <= rbm_pkg::END_RADIUS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbm_pkg::CFG_OPERATION:    r_op        <= i_cfg_data[0];
                rbm_pkg::CFG_ROW_WORDS:    r_row_words <= i_cfg_data[rbm_pkg::ROWW_W-1:0];
                rbm_pkg::CFG_START_RADIUS: r_start     <= i_cfg_data[rbm_pkg::START_W-1:0];
                rbm_pkg::CFG_END_RADIUS:   r_end       <= i_cfg_data[RW-1:0];
                default: r_op <= r_op;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt      <= '0;
            r_idx       <= '0;
            r_bank      <= 1'b0;
            r_a         <= '0;
            r_c         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                if (o_stat.row_done) begin
                    r_wcnt <= '0;
                    r_a    <= RW'(r_start);
                end else begin
                    r_wcnt <= r_wcnt + IW'(1);
                end
            end
            if (i_cmd.pass_begin) begin
                r_c   <= c_next;
                r_idx <= '0;
            end
            if (i_cmd.idx_clr || i_cmd.pass_end) begin
                r_idx <= '0;
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.pass_end) begin
                r_a    <= r_a + r_c;
                r_bank <= !r_bank;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_word = r_out_word;
    assign o_out.row_end     = r_out_end;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || o_out.ready))
        else $error("result word overwritten before it was taken");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_fire && i_cmd.wr_pass))
        else $error("input word and pass word written in the same cycle");

    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pass_end |=> (r_bank != $past(r_bank)))
        else $error("row bank did not swap at end of pass");

    a_reach_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pass_begin |=> ((r_c != '0) &&
            (({1'b0, r_a} + {1'b0, r_c}) <= {1'b0, r_end})))
        else $error("pass reach is zero or overshoots the end radius");

endmodule

>>> rtl/row_bit_morphology_x.sv
// One-dimensional binary dilation (OR) or erosion (AND) of a bit row along x. A row of
// row_words 64-bit words (lowest x first) is taken one word per cycle; after its last
// word the block stops taking words and runs doubling passes that grow the reach from
// start_radius to end_radius, each pass combining the row with copies shifted by +c and
// -c, zeros shifted in. The row sits in a two-bank word memory with two read ports that
// ping-pongs between passes, and each pass word needs three read slots plus a write. A row
// takes its input words, one reach check before each pass and one after the last, and the
// passes (the reach goes from a to 3*a+1, so about log3((2*end+1)/(2*start+1)) passes
// rounded up, none when end is not above start), then a read and a load step per result
// word, the load waiting until the output register is free. The next row is taken from
// the cycle after the last result word is loaded into the output register.
module row_bit_morphology_x #(
    parameter int MAX_ROW_WORDS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rbm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rbm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rbm_in_if.sink                          i_in,
    rbm_out_if.source                       o_out
);

    rbm_pkg::t_cmd  cmd;
    rbm_pkg::t_stat stat;

    rbm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rbm_dp #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in       (i_in),
        .o_out      (o_out)
    );

endmodule

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_WORDS  = 16;
    localparam int ROW_BITS     = STORE_WORDS * rbm_pkg::WORD_BITS;
    localparam int RANDOM_WORDS = 320;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_WAIT  = 20;
    localparam int TAIL_WAIT    = 100;

    typedef struct packed {
        logic [rbm_pkg::WORD_BITS-1:0] word;
        logic                          row_end;
    } t_row_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [rbm_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rbm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rbm_in_if  row_in();
    rbm_out_if row_out();

    row_bit_morphology_x #(
        .MAX_ROW_WORDS(STORE_WORDS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (row_in),
        .o_out     (row_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow of the block's registers and row store
    logic                           pred_op;
    logic [rbm_pkg::ROWW_W-1:0]     pred_row_words;
    logic [rbm_pkg::START_W-1:0]    pred_start;
    logic [rbm_pkg::RAD_W-1:0]      pred_end;
    logic [rbm_pkg::WORD_BITS-1:0]  pred_store [STORE_WORDS];
    int                             pred_count;

    logic [rbm_pkg::WORD_BITS-1:0]  feed_q[$];
    t_row_result                    morph_results_q[$];
    int                             words_queued;
    int                             words_accepted;
    int                             err_count;
    int                             idle_cycles;
    bit                             word_taken;
    bit                             result_taken;
    bit                             in_burst;
    bit                             out_burst;
    int                             in_gap;
    int                             out_stall;

    function automatic int row_span(input int rw);
        if (rw == 0) return 1;
        if (rw > STORE_WORDS) return STORE_WORDS;
        return rw;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [rbm_pkg::WORD_BITS-1:0] rand_word();
        logic [rbm_pkg::WORD_BITS-1:0] w;
        case ($urandom_range(0, 5))
            0: w = {$urandom, $urandom};
            1: begin
                w = '0;
                repeat ($urandom_range(1, 3))
                    w[$urandom_range(0, rbm_pkg::WORD_BITS-1)] = 1'b1;
            end
            2: begin
                w = '1;
                repeat ($urandom_range(1, 3))
                    w[$urandom_range(0, rbm_pkg::WORD_BITS-1)] = 1'b0;
            end
            3: w = '0;
            4: w = '1;
            default: w = {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // takes one row word; on the last word of a row runs the doubling passes
    task automatic absorb_row_word(input logic [rbm_pkg::WORD_BITS-1:0] w);
        int                  len;
        int                  a;
        int                  c;
        int                  target;
        logic [ROW_BITS-1:0] row;
        logic [ROW_BITS-1:0] span_mask;
        logic [ROW_BITS-1:0] up;
        logic [ROW_BITS-1:0] dn;
        t_row_result         r;
        len = row_span(int'(pred_row_words));
        if (pred_count < STORE_WORDS) pred_store[pred_count] = w;
        if (pred_count + 1 < len) begin
            pred_count++;
            return;
        end
        pred_count = 0;
        row = '0;
        for (int i = 0; i < len; i++)
            row[i*rbm_pkg::WORD_BITS +: rbm_pkg::WORD_BITS] = pred_store[i];
        span_mask = {ROW_BITS{1'b1}} >> (ROW_BITS - len * rbm_pkg::WORD_BITS);
        a = int'(pred_start);
        target = int'(pred_end);
        while (a < target) begin
            c = 2 * a + 1;
            if (target - a < c) c = target - a;
            // zeros come in from both ends of the row
            up = (row << c) & span_mask;
            dn = row >> c;
            if (pred_op) row = row & up & dn;
            else         row = (row | up | dn) & span_mask;
            a += c;
        end
        for (int i = 0; i < len; i++) begin
            r.word    = row[i*rbm_pkg::WORD_BITS +: rbm_pkg::WORD_BITS];
            r.row_end = (i == len - 1);
            morph_results_q.push_back(r);
        end
    endtask

    task automatic push_word(input logic [rbm_pkg::WORD_BITS-1:0] w);
        feed_q.push_back(w);
        words_queued++;
    endtask

    // wait until every word is in and every result is out, then let the block go quiet
    task automatic drain_block();
        while (words_accepted != words_queued || morph_results_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [rbm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rbm_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            rbm_pkg::CFG_OPERATION:    pred_op        = data[0];
            rbm_pkg::CFG_ROW_WORDS:    pred_row_words = data[rbm_pkg::ROWW_W-1:0];
            rbm_pkg::CFG_START_RADIUS: pred_start     = data[rbm_pkg::START_W-1:0];
            rbm_pkg::CFG_END_RADIUS:   pred_end       = data[rbm_pkg::RAD_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int op, input int rw, input int st, input int en);
        drain_block();
        write_reg(rbm_pkg::CFG_OPERATION,    rbm_pkg::CFG_DATA_W'(op));
        write_reg(rbm_pkg::CFG_ROW_WORDS,    rbm_pkg::CFG_DATA_W'(rw));
        write_reg(rbm_pkg::CFG_START_RADIUS, rbm_pkg::CFG_DATA_W'(st));
        write_reg(rbm_pkg::CFG_END_RADIUS,   rbm_pkg::CFG_DATA_W'(en));
    endtask

    // word driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            row_in.valid <= 1'b0;
        end else if (row_in.valid && !word_taken) begin
            // hold the word until it is taken
        end else begin
            word_taken = 1'b0;
            if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
            if (in_gap > 0 && !in_burst) begin
                in_gap--;
                row_in.valid <= 1'b0;
            end else if (feed_q.size() != 0) begin
                row_in.valid    <= 1'b1;
                row_in.row_word <= feed_q.pop_front();
                in_gap = pick_gap();
            end else begin
                row_in.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            out_stall = pick_gap();
        end
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        if (out_stall > 0 && !out_burst) begin
            out_stall--;
            row_out.ready <= 1'b0;
        end else begin
            row_out.ready <= 1'b1;
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        t_row_result want;
        bit          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (row_in.valid && row_in.ready) begin
                absorb_row_word(row_in.row_word);
                words_accepted++;
                word_taken = 1'b1;
                moved = 1'b1;
            end
            if (row_out.valid && row_out.ready) begin
                moved = 1'b1;
                result_taken = 1'b1;
                if (morph_results_q.size() == 0) begin
                    $error("unexpected word: result_word %h row_end %b",
                           row_out.result_word, row_out.row_end);
                    err_count++;
                end else begin
                    want = morph_results_q.pop_front();
                    if (row_out.result_word !== want.word) begin
                        $error("result_word: expected %h, got %h",
                               want.word, row_out.result_word);
                        err_count++;
                    end
                    if (row_out.row_end !== want.row_end) begin
                        $error("row_end: expected %b, got %b",
                               want.row_end, row_out.row_end);
                        err_count++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("row_bit_morphology_x test failed");
                $finish;
            end
        end
    end

    initial begin
        int op;
        int rw;
        int st;
        int en;
        int span;
        row_in.valid    = 1'b0;
        row_in.row_word = '0;
        row_out.ready   = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = rbm_pkg::CFG_OPERATION;
        i_cfg_data      = '0;
        i_rst_n         = 1'b0;
        pred_op         = 1'b0;
        pred_row_words  = rbm_pkg::ROW_WORDS_RST;
        pred_start      = '0;
        pred_end        = rbm_pkg::END_RADIUS_RST;
        pred_count      = 0;
        words_queued    = 0;
        words_accepted  = 0;
        err_count       = 0;
        idle_cycles     = 0;
        word_taken      = 1'b0;
        result_taken    = 1'b0;
        in_burst        = 1'b0;
        out_burst       = 1'b0;
        in_gap          = 0;
        out_stall       = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-word rows, reach one
        set_config(0, 1, 0, 1);
        push_word('0);
        push_word('1);
        push_word(64'h8000_0000_0000_0001);
        push_word(64'h0000_0000_0000_0001);
        drain_block();
        write_reg(rbm_pkg::CFG_OPERATION, rbm_pkg::CFG_DATA_W'(1));
        push_word('1);
        push_word(64'h7fff_ffff_ffff_fffe);

        // zero length counts as one word; end below start passes through
        set_config(0, 0, 5, 3);
        push_word(64'h0000_0001_0000_0000);

        // reach beyond the row: erosion clears it, dilation fills it
        set_config(1, 2, 0, 1024);
        push_word('1);
        push_word('1);
        drain_block();
        write_reg(rbm_pkg::CFG_OPERATION, rbm_pkg::CFG_DATA_W'(0));
        push_word('0);
        push_word(64'h0000_0100_0000_0000);

        // length lowered mid-row, counts above the new length
        set_config(1, 4, 0, 2);
        push_word(rand_word());
        push_word(rand_word());
        push_word(rand_word());
        drain_block();
        write_reg(rbm_pkg::CFG_ROW_WORDS, rbm_pkg::CFG_DATA_W'(2));
        push_word(rand_word());
        set_config(0, 3, 1, 4);
        push_word(64'h0000_0000_0001_0000);
        push_word(64'h8000_0000_0000_0000);
        drain_block();
        write_reg(rbm_pkg::CFG_ROW_WORDS, rbm_pkg::CFG_DATA_W'(1));
        push_word(rand_word());

        // largest start and end
        set_config(0, 1, 1023, 2047);
        push_word(64'h0000_0000_0000_8000);

        while (words_queued < 19 + RANDOM_WORDS) begin
            op = $urandom_range(0, 1);
            case ($urandom_range(0, 19))
                0:       rw = 0;
                1:       rw = $urandom_range(17, 31);
                2, 3, 4: rw = $urandom_range(5, 16);
                default: rw = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 3))
                0:       st = 0;
                1:       st = $urandom_range(0, 8);
                2:       st = $urandom_range(0, 1023);
                default: st = $urandom_range(0, 40);
            endcase
            case ($urandom_range(0, 6))
                0:       en = st + $urandom_range(0, 8);
                1:       en = $urandom_range(0, 2047);
                2:       en = 1024;
                3:       en = 2047;
                4:       en = $urandom_range(0, st);
                default: en = $urandom_range(0, 64);
            endcase
            set_config(op, rw, st, en);
            span = row_span(rw);
            repeat ($urandom_range(1, 4) * span) push_word(rand_word());
            // now and then leave a row unfinished for the next setting
            if (span > 1 && $urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, span - 1)) push_word(rand_word());
        end

        drain_block();
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (err_count == 0) begin
            $display("row_bit_morphology_x test passed");
        end else begin
            $display("row_bit_morphology_x test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rbm_pkg.sv
rtl/rbm_ifs.sv
rtl/rbm_ctrl.sv
rtl/rbm_dp.sv
rtl/row_bit_morphology_x.sv
sim/tb_top.sv
